/* sv/chs_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the chained hash set lookup block
// no dependencies

package chs_pkg;

    localparam int KEY_W               = 64;
    localparam int HASH_W              = 32;
    localparam int CFG_W               = 4;
    localparam int DEF_MAX_ENTRIES     = 1024;
    localparam int DEF_MAX_BUCKET_BITS = 10;

    localparam logic [13:0]      HASH_PRIME        = 14'd12289;
    localparam logic [CFG_W-1:0] BUCKET_BITS_RESET = 4'd10;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
    } t_in;

    typedef struct packed {
        logic found;
        logic status;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HEAD,
        ST_HEADW,
        ST_WALK
    } t_state;

endpackage

/* sv/chs_hash.sv */
`timescale 1ns / 1ps
// two-step tile key hash ((z*12289+x)*12289+y) mod 2^32, one register between multiplies
// depends on chs_pkg

module chs_hash
    import chs_pkg::*;
(
    input  logic              i_clk,
    input  logic [KEY_W-1:0]  i_key,
    output logic [HASH_W-1:0] o_hash
);

    logic [7:0]        z;
    logic [27:0]       x;
    logic [27:0]       y;
    logic [21:0]       zp;
    logic [45:0]       hp;
    logic [HASH_W-1:0] r_h1;

    assign z  = i_key[63:56];
    assign x  = i_key[55:28];
    assign y  = i_key[27:0];
    assign zp = 22'(z) * 22'(HASH_PRIME);

    always_ff @(posedge i_clk) begin
        r_h1 <= 32'(zp) + 32'(x);
    end

    assign hp     = 46'(r_h1) * 46'(HASH_PRIME);
    assign o_hash = hp[HASH_W-1:0] + 32'(y);

endmodule

/* sv/chained_hash_set_lookup.sv */
`timescale 1ns / 1ps
// Set of 64-bit tile keys in a chained hash table: bucket head memory plus entry memory.
// An insert steps through ST_HASH, ST_HEAD and ST_HEADW to its registered result strobe;
// a lookup with a valid head also walks the chain in ST_WALK, one entry memory read per
// chain entry compared. A clear, and reset, sweep the bucket head memory one bucket a
// cycle, and busy stays high until 2^MAX_BUCKET_BITS buckets (1024 by default) are swept;
// the clear result strobes at the start of that sweep. Unused commands answer the next
// cycle. Every item gives exactly one result beat on o_valid, which the receiver must take
// as it comes. Depends on chs_pkg and chs_hash.

module chained_hash_set_lookup
    import chs_pkg::*;
#(
    parameter int MAX_ENTRIES     = DEF_MAX_ENTRIES,
    parameter int MAX_BUCKET_BITS = DEF_MAX_BUCKET_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in              i_in,
    output logic             o_valid,
    output t_out             o_result,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int EW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int BW    = MAX_BUCKET_BITS;
    localparam int HW    = 1 + EW;
    localparam int EWORD = 1 + EW + KEY_W;

    t_state             r_state, n_state;
    logic [1:0]         r_cmd, n_cmd;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [BW-1:0]      r_bucket, n_bucket;
    logic [BW-1:0]      r_clr_addr, n_clr_addr;
    logic [CW-1:0]      r_count, n_count;
    logic [CFG_W-1:0]   r_bucket_bits;
    t_out               r_res, n_res;
    logic               r_res_valid, n_res_valid;

    logic [HASH_W-1:0]  hash;
    logic [4:0]         bb;
    logic [BW-1:0]      mask;

    logic [HW-1:0]      bkt_mem [2**BW];
    logic [HW-1:0]      r_bkt_rdata;
    logic [BW-1:0]      bkt_raddr;
    logic               bkt_we;
    logic [BW-1:0]      bkt_waddr;
    logic [HW-1:0]      bkt_wdata;

    logic [EWORD-1:0]   ent_mem [MAX_ENTRIES];
    logic [EWORD-1:0]   r_ent_rdata;
    logic [EW-1:0]      ent_raddr;
    logic               ent_we;
    logic [EW-1:0]      ent_waddr;
    logic [EWORD-1:0]   ent_wdata;

    logic               hd_v;
    logic [EW-1:0]      hd_idx;
    logic               lk_v;
    logic [EW-1:0]      lk_idx;
    logic [KEY_W-1:0]   ent_key;
    logic               full;

    chs_hash u_hash (
        .i_clk  (i_clk),
        .i_key  (r_key),
        .o_hash (hash)
    );

    assign bb        = (r_bucket_bits > MAX_BUCKET_BITS) ? 5'(MAX_BUCKET_BITS)
                                                         : 5'(r_bucket_bits);
    assign mask      = ~({BW{1'b1}} << bb);
    assign bkt_raddr = hash[BW-1:0] & mask;

    assign hd_v    = r_bkt_rdata[HW-1];
    assign hd_idx  = r_bkt_rdata[EW-1:0];
    assign lk_v    = r_ent_rdata[EWORD-1];
    assign lk_idx  = r_ent_rdata[KEY_W +: EW];
    assign ent_key = r_ent_rdata[KEY_W-1:0];
    assign full    = (r_count == CW'(MAX_ENTRIES));

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        r_bkt_rdata <= bkt_mem[bkt_raddr];
    end

    // entry memory: link valid, link, key
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        r_ent_rdata <= ent_mem[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_addr    <= '0;
            r_count       <= '0;
            r_bucket_bits <= BUCKET_BITS_RESET;
            r_res_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_bucket_bits <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_bucket <= n_bucket;
        r_res    <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_bucket    = r_bucket;
        n_clr_addr  = r_clr_addr;
        n_count     = r_count;
        n_res       = r_res;
        n_res_valid = 1'b0;
        bkt_we      = 1'b0;
        bkt_waddr   = r_bucket;
        bkt_wdata   = {1'b1, r_count[EW-1:0]};
        ent_we      = 1'b0;
        ent_waddr   = r_count[EW-1:0];
        ent_wdata   = {hd_v, hd_idx, r_key};
        ent_raddr   = hd_idx;

        unique case (r_state)
            ST_CLEAR: begin
                bkt_we     = 1'b1;
                bkt_waddr  = r_clr_addr;
                bkt_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {BW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_cmd = i_in.cmd;
                    n_key = i_in.key;
                    priority case (i_in.cmd)
                        CMD_INSERT, CMD_LOOKUP: begin
                            n_state = ST_HASH;
                        end
                        CMD_CLEAR: begin
                            n_state     = ST_CLEAR;
                            n_clr_addr  = '0;
                            n_count     = '0;
                            n_res       = '0;
                            n_res_valid = 1'b1;
                        end
                        default: begin
                            n_res       = '0;
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_HASH: begin
                n_state = ST_HEAD;
            end
            ST_HEAD: begin
                n_bucket = bkt_raddr;
                n_state  = ST_HEADW;
            end
            ST_HEADW: begin
                if (r_cmd == CMD_INSERT) begin
                    n_state     = ST_IDLE;
                    n_res_valid = 1'b1;
                    n_res.found = 1'b0;
                    if (full) begin
                        n_res.status = 1'b1;
                    end else begin
                        n_res.status = 1'b0;
                        bkt_we       = 1'b1;
                        ent_we       = 1'b1;
                        n_count      = r_count + 1'b1;
                    end
                end else if (!hd_v) begin
                    n_state     = ST_IDLE;
                    n_res       = '0;
                    n_res_valid = 1'b1;
                end else begin
                    ent_raddr = hd_idx;
                    n_state   = ST_WALK;
                end
            end
            ST_WALK: begin
                if (ent_key == r_key) begin
                    n_state      = ST_IDLE;
                    n_res.found  = 1'b1;
                    n_res.status = 1'b0;
                    n_res_valid  = 1'b1;
                end else if (lk_v) begin
                    ent_raddr = lk_idx;
                end else begin
                    n_state     = ST_IDLE;
                    n_res       = '0;
                    n_res_valid = 1'b1;
                end
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_res_valid;
    assign o_result = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_we |=> (r_count == $past(r_count) + 1'b1))
        else $error("entry write without count advance");

    a_clear_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !ent_we)
        else $error("entry write during bucket sweep");

    a_lookup_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.cmd == CMD_LOOKUP) |=> !o_valid)
        else $error("lookup answered before walk");

    a_walk_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_cmd == CMD_LOOKUP))
        else $error("chain walk for non-lookup beat");

endmodule

/* test/tb_chained_hash_set_lookup.sv */
`timescale 1ns / 1ps
// testbench for chained_hash_set_lookup: random and directed insert, lookup, clear, unused
// commands checked beat by beat against a table model held in the bench; needs chs_pkg

module tb_chained_hash_set_lookup;
    import chs_pkg::*;

    localparam int          MAX_ENT      = DEF_MAX_ENTRIES;
    localparam int          BUCKETS      = 1 << DEF_MAX_BUCKET_BITS;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int          QUIET_LIMIT  = 20000;
    localparam int          DRAIN_CYCLES = 1100;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    t_in              cmd_beat;
    logic             reply_valid;
    t_out             reply;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    t_in              command_q[$];
    t_out             reply_q[$];
    logic [63:0]      stored_keys[$];
    bit               beat_taken = 1'b0;
    int               idle_pct;
    int               errors = 0;
    int               quiet_cycles = 0;

    // bench copy of the table
    logic [CFG_W-1:0] bucket_bits_cfg = BUCKET_BITS_RESET;
    int unsigned      head_idx[BUCKETS];
    bit               head_ok[BUCKETS];
    logic [63:0]      ent_key[MAX_ENT];
    int unsigned      ent_next[MAX_ENT];
    bit               ent_next_ok[MAX_ENT];
    int unsigned      ent_used = 0;

    int n_insert = 0, n_refused = 0, n_lookup = 0, n_hit = 0;
    int n_clear = 0, n_unused = 0, n_cfg = 0;

    chained_hash_set_lookup u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (cmd_beat),
        .o_valid    (reply_valid),
        .o_result   (reply),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned tile_bucket(logic [63:0] key);
        logic [31:0] h;
        int unsigned bb;
        bb = (bucket_bits_cfg > DEF_MAX_BUCKET_BITS) ? DEF_MAX_BUCKET_BITS : bucket_bits_cfg;
        h = 32'(key[63:56]);
        h = h * 32'(HASH_PRIME) + 32'(key[55:28]);
        h = h * 32'(HASH_PRIME) + 32'(key[27:0]);
        return h & ((32'd1 << bb) - 32'd1);
    endfunction

    function automatic t_out set_command_reply(t_in item);
        t_out r;
        int unsigned b, e, steps;
        bit ok;
        r = '0;
        case (item.cmd)
            CMD_INSERT: begin
                n_insert++;
                if (ent_used >= MAX_ENT) begin
                    r.status = 1'b1;
                    n_refused++;
                end else begin
                    b = tile_bucket(item.key);
                    e = ent_used;
                    ent_key[e]     = item.key;
                    ent_next[e]    = head_idx[b];
                    ent_next_ok[e] = head_ok[b];
                    head_idx[b]    = e;
                    head_ok[b]     = 1'b1;
                    ent_used       = e + 1;
                end
            end
            CMD_LOOKUP: begin
                n_lookup++;
                b = tile_bucket(item.key);
                ok = head_ok[b];
                e = head_idx[b];
                steps = 0;
                while (ok && e < MAX_ENT && steps < MAX_ENT && !r.found) begin
                    if (ent_key[e] == item.key) begin
                        r.found = 1'b1;
                    end else begin
                        ok = ent_next_ok[e];
                        e = ent_next[e];
                        steps++;
                    end
                end
                if (r.found) n_hit++;
            end
            CMD_CLEAR: begin
                n_clear++;
                foreach (head_ok[i]) head_ok[i] = 1'b0;
                ent_used = 0;
            end
            default: begin
                n_unused++;
            end
        endcase
        return r;
    endfunction

    // driver: new beat offered at the falling edge once the previous one was taken
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!start || beat_taken) begin
            beat_taken = 1'b0;
            if (command_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                start    <= 1'b1;
                cmd_beat <= command_q.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: reply check, config tracking and command capture
    t_out want;
    always @(posedge clk) begin
        if (rst_n) begin
            if (reply_valid) begin
                if (reply_q.size() == 0) begin
                    $error("reply beat with no command outstanding");
                    errors++;
                end else begin
                    want = reply_q.pop_front();
                    if (reply.found !== want.found) begin
                        $error("found: expected %0b, got %0b", want.found, reply.found);
                        errors++;
                    end
                    if (reply.status !== want.status) begin
                        $error("status: expected %0b, got %0b", want.status, reply.status);
                        errors++;
                    end
                end
            end
            if (cfg_we) bucket_bits_cfg = cfg_data;
            if (start && !busy) begin
                reply_q.push_back(set_command_reply(cmd_beat));
                beat_taken = 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && !(start && !busy) && !reply_valid) quiet_cycles++;
        else quiet_cycles = 0;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_cmd(logic [1:0] c, logic [63:0] key);
        t_in item;
        item.cmd = c;
        item.key = key;
        command_q.push_back(item);
        if (c == CMD_CLEAR) stored_keys.delete();
        if (c == CMD_INSERT) stored_keys.push_back(key);
    endtask

    // idle is judged at the rising edge, where start and the queues are settled
    task automatic write_bucket_bits(logic [CFG_W-1:0] v);
        @(posedge clk);
        while (command_q.size() != 0 || start || reply_q.size() != 0 || busy)
            @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        n_cfg++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] coord_key();
        logic [7:0]  z;
        logic [27:0] x, y;
        int r;
        r = $urandom_range(9);
        z = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
        r = $urandom_range(9);
        x = (r == 0) ? 28'h0 : (r == 1) ? 28'hFFFFFFF : 28'($urandom);
        r = $urandom_range(9);
        y = (r == 0) ? 28'h0 : (r == 1) ? 28'hFFFFFFF : 28'($urandom);
        return {z, x, y};
    endfunction

    function automatic logic [63:0] probe_key();
        int r;
        logic [63:0] k;
        r = $urandom_range(99);
        if (stored_keys.size() == 0 || r >= 75) return coord_key();
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
        if (r >= 60) k = k ^ (64'd1 << $urandom_range(63));
        return k;
    endfunction

    task automatic queue_mix(int n, bit clear_first);
        int r;
        if (clear_first) push_cmd(CMD_CLEAR, coord_key());
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 45) push_cmd(CMD_INSERT, coord_key());
            else if (r < 88) push_cmd(CMD_LOOKUP, probe_key());
            else if (r < 93) push_cmd(CMD_CLEAR, coord_key());
            else push_cmd(CMD_UNUSED, coord_key());
        end
    endtask

    task automatic queue_fill();
        int ins;
        ins = 0;
        push_cmd(CMD_CLEAR, 64'd0);
        while (ins < MAX_ENT + 8) begin
            if ($urandom_range(9) == 0) begin
                push_cmd(CMD_LOOKUP, probe_key());
            end else begin
                push_cmd(CMD_INSERT, coord_key());
                ins++;
            end
        end
        repeat (12) push_cmd(CMD_LOOKUP, probe_key());
    endtask

    initial begin
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd_beat = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        idle_pct = 17;
        foreach (head_ok[i]) head_ok[i] = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, duplicates, unused command, clear
        push_cmd(CMD_INSERT, 64'd0);
        push_cmd(CMD_INSERT, '1);
        push_cmd(CMD_INSERT, {8'hFF, 28'h0, 28'hFFFFFFF});
        push_cmd(CMD_INSERT, {8'h00, 28'hFFFFFFF, 28'h0});
        push_cmd(CMD_LOOKUP, 64'd0);
        push_cmd(CMD_LOOKUP, '1);
        push_cmd(CMD_LOOKUP, {8'hFF, 28'h0, 28'hFFFFFFF});
        push_cmd(CMD_LOOKUP, {8'h00, 28'hFFFFFFF, 28'h0});
        push_cmd(CMD_LOOKUP, 64'd1);
        push_cmd(CMD_INSERT, 64'd0);
        push_cmd(CMD_LOOKUP, 64'd0);
        push_cmd(CMD_UNUSED, '1);
        push_cmd(CMD_LOOKUP, 64'h5);
        push_cmd(CMD_CLEAR, '1);
        push_cmd(CMD_LOOKUP, 64'd0);
        push_cmd(CMD_LOOKUP, '1);
        push_cmd(CMD_INSERT, 64'h0123_4567_89AB_CDEF);
        push_cmd(CMD_LOOKUP, 64'h0123_4567_89AB_CDEF);
        push_cmd(CMD_UNUSED, 64'd0);

        write_bucket_bits(4'd0);
        queue_mix(40, 1'b1);
        write_bucket_bits(4'd15);
        queue_mix(40, 1'b0);
        write_bucket_bits(4'd3);
        queue_mix(50, 1'b0);

        idle_pct = 87;
        write_bucket_bits(4'd10);
        queue_fill();
        write_bucket_bits(4'd1);
        queue_mix(40, 1'b0);
        write_bucket_bits(4'd7);
        queue_mix(50, 1'b1);

        idle_pct = 0;
        write_bucket_bits(4'd12);
        queue_mix(50, 1'b0);
        write_bucket_bits(4'd5);
        queue_mix(50, 1'b0);
        write_bucket_bits(4'd10);
        queue_mix(50, 1'b0);

        while (command_q.size() != 0 || start || reply_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d inserts (%0d refused on a full store), %0d lookups (%0d hits)",
                 n_insert, n_refused, n_lookup, n_hit);
        $display("plus %0d clears, %0d unused commands, %0d bucket_bits writes",
                 n_clear, n_unused, n_cfg);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
